// ----- src/small_arg_reduce_pio2f_core_macros.svh -----
// Assertion macros for the small-argument pi/2 reducer.
// Used by sarp2f_ctrl; expects clk_i and rst_ni in scope.
`ifndef SMALL_ARG_REDUCE_PIO2F_CORE_MACROS_SVH
`define SMALL_ARG_REDUCE_PIO2F_CORE_MACROS_SVH

// same-cycle implication
`define SARP2F_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define SARP2F_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) else $error(msg);

`endif

// ----- src/sarp2f_pkg.sv -----
// Package for the small-argument pi/2 reducer: word types, command struct,
// bucket boundaries and the three-part constants of n*pi/2. No dependencies.
package sarp2f_pkg;

  typedef struct packed {
    logic [31:0] x_bits;
    logic [14:0] top_half;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        reduced_bits;
    logic signed [3:0]  quadrant;
    logic               out_of_range;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] part_sel;
    logic       out_load;
  } cmd_t;

  localparam logic [14:0] SmallLimit = 15'h40e2;
  localparam logic [14:0] BoundHi0 = 15'h4016;
  localparam logic [14:0] BoundHi1 = 15'h407b;
  localparam logic [14:0] BoundHi2 = 15'h40af;
  localparam logic [15:0] BoundLo0 = 16'hcbe4;
  localparam logic [15:0] BoundLo1 = 16'h53d1;
  localparam logic [15:0] BoundLo2 = 16'heddf;
  localparam logic [31:0] QuietBit = 32'h0040_0000;

  // part k of (idx+1)*pi/2, single bits
  function automatic logic [31:0] sarp2f_part(input logic [1:0] idx, input logic [1:0] k);
    logic [31:0] r;
    case ({idx, k})
      4'h0:    r = 32'h3fc9_0fdb;
      4'h1:    r = 32'hb33b_bd2e;
      4'h2:    r = 32'ha6f7_2ced;
      4'h4:    r = 32'h4049_0fdb;
      4'h5:    r = 32'hb3bb_bd2e;
      4'h6:    r = 32'ha777_2ced;
      4'h8:    r = 32'h4096_cbe4;
      4'h9:    r = 32'hb24c_de2e;
      4'ha:    r = 32'h2553_c9ca;
      4'hc:    r = 32'h40c9_0fdb;
      4'hd:    r = 32'hb43b_bd2e;
      4'he:    r = 32'ha7f7_2ced;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/sarp2f_fadd.sv -----
// Single-precision adder, round to nearest even, finite operands.
// Depends on nothing; used by sarp2f_dp.
module sarp2f_fadd (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);

  logic        swap;
  logic [31:0] lg, sm;
  logic [7:0]  el, es, d, lim;
  logic [23:0] ml, ms;
  logic [26:0] ext, al, nm;
  logic [27:0] sum;
  logic [4:0]  lz, sh;
  logic [8:0]  ne;
  logic [7:0]  expf;
  logic        up;
  logic [30:0] body;

  assign swap = b_i[30:0] > a_i[30:0];
  assign lg   = swap ? b_i : a_i;
  assign sm   = swap ? a_i : b_i;
  assign el   = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
  assign es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
  assign ml   = {lg[30:23] != 8'd0, lg[22:0]};
  assign ms   = {sm[30:23] != 8'd0, sm[22:0]};
  assign d    = el - es;
  assign ext  = {ms, 3'b000};
  assign lim  = el - 8'd1;

  always_comb begin
    if (d >= 8'd27) begin
      al = {26'd0, |ms};
    end else begin
      al = (ext >> d);
      al[0] = al[0] | (|(ext & ((27'd1 << d) - 27'd1)));
    end
    if (lg[31] == sm[31]) begin
      sum = {1'b0, ml, 3'b000} + {1'b0, al};
    end else begin
      sum = {1'b0, ml, 3'b000} - {1'b0, al};
    end
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz = 5'(26 - i);
    end
    if (sum[27]) begin
      sh = 5'd0;
      nm = {sum[27:2], sum[1] | sum[0]};
      ne = {1'b0, el} + 9'd1;
    end else begin
      sh = ({3'b000, lz} > lim) ? lim[4:0] : lz;
      nm = sum[26:0] << sh;
      ne = {1'b0, el} - {4'd0, sh};
    end
    expf = nm[26] ? ne[7:0] : 8'd0;
    up   = nm[2] & (nm[1] | nm[0] | nm[3]);
    // carry out of the fraction lands in the exponent field
    body = {expf, nm[25:3]} + {30'd0, up};
    if (sum == 28'd0) begin
      sum_o = 32'd0;
    end else begin
      sum_o = {lg[31], body};
    end
  end

endmodule

// ----- src/sarp2f_dp.sv -----
// Datapath: bucket pick, accumulator with one shared float adder, output register.
// Depends on sarp2f_pkg and sarp2f_fadd.
module sarp2f_dp
  import sarp2f_pkg::*;
(
  input  logic      clk_i,
  input  cmd_t      cmd_i,
  input  in_word_t  in_word_i,
  output out_word_t out_word_o
);

  logic [31:0] acc_q, acc_d, mag, part, add_res;
  logic [1:0]  nidx_q, nidx_d;
  logic        neg_q, oor_q, skip_q;
  logic [3:0]  n4;
  out_word_t   out_q;

  assign mag = {1'b0, in_word_i.x_bits[30:0]};

  always_comb begin
    nidx_d = 2'd0;
    if (in_word_i.top_half >= BoundHi0) nidx_d = 2'd1;
    if (in_word_i.top_half >= BoundHi1) nidx_d = 2'd2;
    if (in_word_i.top_half >= BoundHi2) nidx_d = 2'd3;
    case (nidx_d)
      2'd1: if (in_word_i.top_half == BoundHi0 && in_word_i.x_bits[15:0] < BoundLo0)
              nidx_d = 2'd0;
      2'd2: if (in_word_i.top_half == BoundHi1 && in_word_i.x_bits[15:0] < BoundLo1)
              nidx_d = 2'd1;
      2'd3: if (in_word_i.top_half == BoundHi2 && in_word_i.x_bits[15:0] < BoundLo2)
              nidx_d = 2'd2;
      default: ;
    endcase
  end

  assign part = sarp2f_part(nidx_q, cmd_i.part_sel);

  sarp2f_fadd u_fadd (
    .a_i  (acc_q),
    .b_i  ({~part[31], part[30:0]}),
    .sum_o(add_res)
  );

  assign acc_d = (cmd_i.step && !skip_q && !oor_q) ? add_res : acc_q;
  assign n4    = {2'b00, nidx_q} + 4'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nidx_q <= nidx_d;
      neg_q  <= in_word_i.x_bits[31];
      oor_q  <= in_word_i.top_half >= SmallLimit;
      skip_q <= mag[30:23] == 8'hff;
      // NaN gets its quiet bit; infinities pass unchanged
      acc_q  <= (mag > 32'h7f80_0000) ? (mag | QuietBit) : mag;
    end else begin
      acc_q  <= acc_d;
    end
    if (cmd_i.out_load) begin
      if (oor_q) begin
        out_q <= '{reduced_bits: 32'd0, quadrant: 4'sd0, out_of_range: 1'b1};
      end else begin
        out_q.reduced_bits <= acc_d ^ {neg_q, 31'd0};
        out_q.quadrant     <= neg_q ? -n4 : n4;
        out_q.out_of_range <= 1'b0;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ----- src/sarp2f_ctrl.sv -----
// Controller: sequences load, three adder steps and the output register handoff.
// Depends on sarp2f_pkg and small_arg_reduce_pio2f_core_macros.svh.
`include "small_arg_reduce_pio2f_core_macros.svh"
module sarp2f_ctrl
  import sarp2f_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0] state_q, state_d, cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d, out_free, accept;

  assign in_stall_o = state_q != StIdle;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.part_sel = cnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = 2'd0;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          // last part: result goes straight to the output word if free
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = StIdle;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SARP2F_ASSERT_NEXT(a_accept_run, accept, state_q == StRun && cnt_q == 2'd0, "accept did not start run")
  `SARP2F_ASSERT_NEXT(a_hold, state_q == StRun && cnt_q == 2'd2 && !out_free, state_q == StHold, "blocked result not held")
  `SARP2F_ASSERT_NEXT(a_load_valid, cmd_o.out_load, out_valid_q, "loaded word not valid")
  `SARP2F_ASSERT_NOW(a_step_run, cmd_o.step, state_q == StRun && !cmd_o.load, "step outside run")

endmodule

// ----- src/small_arg_reduce_pio2f_core.sv -----
// Small-argument reduction of a single by n*pi/2, n = 1..4, three-part constants.
// Sequence: load the accepted word, run three adder steps, then load the output register.
// One float adder does the three parts; input stalls until the output register loads.
// The output register frees the input side while a result waits to be taken.
// Reset (async, active low) clears control state only; no clearing pass.
module small_arg_reduce_pio2f_core
  import sarp2f_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cmd_t cmd;

  sarp2f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  sarp2f_dp u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .in_word_i (in_word_i),
    .out_word_o(out_word_o)
  );

endmodule

// ----- tb/small_arg_reduce_pio2f_core_tb.sv -----
// Testbench for small_arg_reduce_pio2f_core: directed table, then random words,
// each checked against a typed-in word or a bit-exact single-precision predictor.
// Depends on sarp2f_pkg for the word types and bucket boundaries.
module small_arg_reduce_pio2f_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sarp2f_pkg::*;

  localparam int RandWords = 1150;

  typedef struct packed {
    in_word_t  w;
    logic      fixed;   // expected result typed in below
    out_word_t e;
  } row_t;

  localparam int NumRows = 22;
  localparam row_t Rows[NumRows] = '{
    '{'{32'h0000_0000, 15'h0000}, 1'b0, '0},
    '{'{32'h8000_0000, 15'h0000}, 1'b0, '0},
    '{'{32'h0000_0001, 15'h0000}, 1'b0, '0},
    '{'{32'h3f80_0000, 15'h3f80}, 1'b0, '0},
    '{'{32'h4016_cbe3, 15'h4016}, 1'b0, '0},
    '{'{32'h4016_cbe4, 15'h4016}, 1'b0, '0},
    '{'{32'hc07b_53d0, 15'h407b}, 1'b0, '0},
    '{'{32'h407b_53d1, 15'h407b}, 1'b0, '0},
    '{'{32'h40af_edde, 15'h40af}, 1'b0, '0},
    '{'{32'hc0af_eddf, 15'h40af}, 1'b0, '0},
    '{'{32'h40e1_ffff, 15'h40e1}, 1'b0, '0},
    '{'{32'h40af_ffff, 15'h4000}, 1'b0, '0},
    '{'{32'h7f7f_ffff, 15'h0000}, 1'b0, '0},
    '{'{32'hffff_ffff, 15'h40e1}, 1'b0, '0},
    '{'{32'h40e2_0000, 15'h40e2}, 1'b1, '{32'h0, 4'sd0, 1'b1}},
    '{'{32'hffff_ffff, 15'h7fff}, 1'b1, '{32'h0, 4'sd0, 1'b1}},
    '{'{32'h7f80_0000, 15'h7f80}, 1'b1, '{32'h0, 4'sd0, 1'b1}},
    '{'{32'h7f80_0001, 15'h0000}, 1'b1, '{32'h7fc0_0001, 4'sd1, 1'b0}},
    '{'{32'hff80_0001, 15'h0000}, 1'b1, '{32'hffc0_0001, -4'sd1, 1'b0}},
    '{'{32'h7f80_0000, 15'h0000}, 1'b1, '{32'h7f80_0000, 4'sd1, 1'b0}},
    '{'{32'hff80_0000, 15'h0000}, 1'b1, '{32'hff80_0000, -4'sd1, 1'b0}},
    '{'{32'h40c9_0fdb, 15'h40c9}, 1'b0, '0}
  };

  // three split parts of n*pi/2, single bits, n = 1..4
  localparam logic [31:0] PiParts[12] = '{
    32'h3fc9_0fdb, 32'hb33b_bd2e, 32'ha6f7_2ced,
    32'h4049_0fdb, 32'hb3bb_bd2e, 32'ha777_2ced,
    32'h4096_cbe4, 32'hb24c_de2e, 32'h2553_c9ca,
    32'h40c9_0fdb, 32'hb43b_bd2e, 32'ha7f7_2ced
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  out_word_t pending_q[$];
  int        errors = 0;
  bit        calm = 1'b0;

  small_arg_reduce_pio2f_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic real sgl_to_real(input logic [31:0] b);
    logic [63:0] d;
    real r;
    if (b[30:23] == 8'hff) begin
      d = {b[31], 11'h7ff, 52'h0};
      return $bitstoreal(d);
    end
    if (b[30:23] == 8'h00) begin
      r = b[22:0] * (2.0 ** -149);
      return b[31] ? -r : r;
    end
    d = {b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'h0};
    return $bitstoreal(d);
  endfunction

  // round a double to single, nearest even; double rounding is harmless for a - b
  function automatic logic [31:0] real_to_sgl(input real r);
    logic [63:0] d;
    logic [63:0] sig, kept, rem, half, mag;
    int ex, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff) return {d[63], 8'hff, 23'h0};
    if (d[62:52] == 11'h000) return {d[63], 31'h0};
    ex = int'(d[62:52]) - 1023;
    sig = {11'h0, 1'b1, d[51:0]};
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 54) return {d[63], 31'h0};
    kept = sig >> sh;
    rem = sig & ((64'h1 << sh) - 1);
    half = 64'h1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    if (ex >= -126) mag = (64'(ex + 126) << 23) + kept;
    else mag = kept;
    if (mag >= 64'h7f80_0000) return {d[63], 8'hff, 23'h0};
    return {d[63], mag[30:0]};
  endfunction

  function automatic out_word_t reduce_word(input in_word_t w);
    out_word_t o;
    logic [31:0] mag, rem;
    logic [15:0] low;
    int n;
    real acc;
    o = '0;
    if (w.top_half >= SmallLimit) begin
      o.out_of_range = 1'b1;
      return o;
    end
    mag = {1'b0, w.x_bits[30:0]};
    low = w.x_bits[15:0];
    n = 1;
    if (w.top_half >= BoundHi0) n = 2;
    if (w.top_half >= BoundHi1) n = 3;
    if (w.top_half >= BoundHi2) n = 4;
    // tie on the top half: low half of x picks the side
    if ((n == 2 && w.top_half == BoundHi0 && low < BoundLo0) ||
        (n == 3 && w.top_half == BoundHi1 && low < BoundLo1) ||
        (n == 4 && w.top_half == BoundHi2 && low < BoundLo2)) n--;
    if (mag > 32'h7f80_0000) begin
      rem = mag | QuietBit;
    end else begin
      rem = mag;
      for (int k = 0; k < 3; k++) begin
        acc = sgl_to_real(rem) - sgl_to_real(PiParts[3*(n-1)+k]);
        rem = real_to_sgl(acc);
      end
    end
    o.quadrant = 4'(n);
    if (w.x_bits[31]) begin
      rem[31] = ~rem[31];
      o.quadrant = -o.quadrant;
    end
    o.reduced_bits = rem;
    return o;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    logic [14:0] hi[3];
    int sel;
    hi = '{BoundHi0, BoundHi1, BoundHi2};
    w.x_bits = $urandom;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        w.x_bits[30:16] = 15'($urandom_range(16'h3e00, 16'h40e1));
        w.top_half = w.x_bits[30:16];
      end
      4, 5: begin
        w.x_bits[30:16] = hi[$urandom_range(0, 2)];
        w.top_half = w.x_bits[30:16];
      end
      6: begin
        w.x_bits[30:16] = 15'($urandom_range(0, 16'h40e1));
        w.top_half = w.x_bits[30:16];
      end
      7: begin
        w.x_bits[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        w.top_half = 15'($urandom_range(0, 16'h40e1));
      end
      default: w.top_half = 15'($urandom);
    endcase
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input logic fixed, input out_word_t e);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(fixed ? e : reduce_word(w));
    @(negedge clk_i);
  endtask

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (calm) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 7) == 0) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 2) == 0) out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_word_o);
        errors++;
      end else begin
        exp_w = pending_q.pop_front();
        if (out_word_o.reduced_bits !== exp_w.reduced_bits ||
            out_word_o.quadrant !== exp_w.quadrant ||
            out_word_o.out_of_range !== exp_w.out_of_range) begin
          $display("%0t: mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
                   exp_w.reduced_bits, exp_w.quadrant, exp_w.out_of_range,
                   out_word_o.reduced_bits, out_word_o.quadrant,
                   out_word_o.out_of_range);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (Rows[i]) send_word(Rows[i].w, Rows[i].fixed, Rows[i].e);
    for (int i = 0; i < RandWords; i++) begin
      if (i == RandWords / 2) begin
        in_valid_i <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      if (i == RandWords - 150) calm = 1'b1;
      send_word(random_word(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_q.size() != 0 && waited < 1000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
